/* src/sbe_pkg.sv */
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared constants, command codes and beat types of the sparse bitset engine.
// ----------------------------------------------------------------------------
package sbe_pkg;

  localparam int WORD_BITS = 64;
  localparam int MAX_WORDS = 64;
  localparam int IDX_W     = $clog2(MAX_WORDS);
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int SIZE_W    = 13;
  localparam int DATA_W    = 64;
  localparam int SHIFT_W   = $clog2(WORD_BITS);

  typedef enum logic [2:0] {
    CMD_RESTART   = 3'd0,
    CMD_WRITE     = 3'd1,
    CMD_LOAD_OP   = 3'd2,
    CMD_READ      = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_OR_MASK   = 3'd5,
    CMD_INTERSECT = 3'd6,
    CMD_FIND      = 3'd7
  } cmd_t;

  typedef struct packed {
    cmd_t               command;
    logic [IDX_W-1:0]   word_index;
    logic [DATA_W-1:0]  data_word;
  } in_beat_t;

  typedef struct packed {
    logic               none_active;
    logic               found;
    logic [IDX_W-1:0]   found_position;
    logic [DATA_W-1:0]  read_data;
    logic [CNT_W-1:0]   active_words;
  } out_beat_t;

endpackage

/* src/sbe_ram.sv */
// ----------------------------------------------------------------------------
// sbe_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sbe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/sparse_bitset_engine.sv */
// ----------------------------------------------------------------------------
// sparse_bitset_engine
// Sparse bitset over word, mask and operand memories with an active list.
//
// A command beat is taken when start is high and busy is low. Exactly one
// result beat follows, on result for the single cycle that done is high;
// the receiver cannot stall it. set_size_bits is written through cfg_we and
// cfg_data and takes effect on the next restart; the user must write it only
// while the block is idle, which the block itself does not enforce.
// Restart, write word and load operand answer in the next cycle, read word
// after a read-wait state. Clear mask, OR mask, intersect and find walk the
// active list, each active entry by list read, store read, and modify and
// write back. Find ends at its first hit. An empty list answers without a walk.
// Reset clears the active count and the size register; per-entry valid bits
// make the word and mask stores read as zero and the active list as identity
// at once, so no clearing pass is needed. busy is high during a read or a walk.
// ----------------------------------------------------------------------------
module sparse_bitset_engine
  import sbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  in_beat_t          cmd,
  output logic              done,
  output out_beat_t         result,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RDWAIT,
    S_LIST,
    S_DATA,
    S_EXEC
  } state_t;

  state_t                 state;
  cmd_t                   op;
  logic [IDX_W-1:0]       idx;
  logic [SIZE_W-1:0]      set_size_bits;
  logic [CNT_W-1:0]       count;
  logic [IDX_W-1:0]       slot;
  logic [IDX_W-1:0]       pos;
  logic [IDX_W-1:0]       last_pos;
  logic [MAX_WORDS-1:0]   word_valid;
  logic [MAX_WORDS-1:0]   mask_valid;
  logic [MAX_WORDS-1:0]   list_valid;

  logic                   word_we;
  logic [IDX_W-1:0]       word_waddr;
  logic [WORD_BITS-1:0]   word_wdata;
  logic [IDX_W-1:0]       word_raddr;
  logic [WORD_BITS-1:0]   word_rdata;
  logic                   mask_we;
  logic [WORD_BITS-1:0]   mask_wdata;
  logic [IDX_W-1:0]       data_raddr;
  logic [WORD_BITS-1:0]   mask_rdata;
  logic                   op_we;
  logic [WORD_BITS-1:0]   op_rdata;
  logic                   list_we;
  logic [IDX_W-1:0]       list_rdata;
  logic [IDX_W-1:0]       last_rdata;
  logic [IDX_W-1:0]       last_slot;

  logic [IDX_W-1:0]       pos_next;
  logic [IDX_W-1:0]       last_next;
  logic [WORD_BITS-1:0]   cur_word;
  logic [WORD_BITS-1:0]   cur_mask;
  logic [WORD_BITS-1:0]   and_word;
  logic                   drop;
  logic                   hit;
  logic                   walk_end;
  logic [CNT_W-1:0]       count_next;
  logic [SIZE_W:0]        size_round;
  logic [SIZE_W-SHIFT_W:0] words_raw;
  logic [CNT_W-1:0]       restart_count;
  logic [CNT_W-1:0]       accept_count;
  logic                   done_next;

  assign last_slot  = IDX_W'(count - CNT_W'(1));
  assign pos_next   = list_valid[slot] ? list_rdata : slot;
  assign last_next  = list_valid[last_slot] ? last_rdata : last_slot;
  assign cur_word   = word_valid[pos] ? word_rdata : '0;
  assign cur_mask   = mask_valid[pos] ? mask_rdata : '0;
  assign and_word   = cur_word & cur_mask;
  assign drop       = (op == CMD_INTERSECT) && (and_word != cur_word) && (and_word == '0);
  assign hit        = (op == CMD_FIND) && ((cur_word & op_rdata) != '0);
  assign count_next = drop ? count - CNT_W'(1) : count;
  assign walk_end   = (op == CMD_INTERSECT) ? (slot == '0)
                                            : ((CNT_W'(slot) + CNT_W'(1)) == count);

  assign size_round = {1'b0, set_size_bits} + (SIZE_W+1)'(WORD_BITS - 1);
  assign words_raw  = size_round[SIZE_W:SHIFT_W];
  assign restart_count = (words_raw > (SIZE_W-SHIFT_W+1)'(MAX_WORDS))
                         ? CNT_W'(MAX_WORDS) : CNT_W'(words_raw);
  assign accept_count  = (cmd.command == CMD_RESTART) ? restart_count : count;

  assign busy = (state != S_IDLE);

  always_comb begin
    word_we    = 1'b0;
    word_waddr = pos;
    word_wdata = and_word;
    word_raddr = pos_next;
    data_raddr = pos_next;
    mask_we    = 1'b0;
    mask_wdata = cur_mask | op_rdata;
    op_we      = 1'b0;
    list_we    = 1'b0;
    if (state == S_IDLE) begin
      word_raddr = cmd.word_index;
      word_waddr = cmd.word_index;
      word_wdata = cmd.data_word[WORD_BITS-1:0];
      if (start) begin
        word_we = (cmd.command == CMD_WRITE);
        op_we   = (cmd.command == CMD_LOAD_OP);
      end
    end else if (state == S_EXEC) begin
      word_we = (op == CMD_INTERSECT) && (and_word != cur_word);
      mask_we = (op == CMD_OR_MASK);
      list_we = drop;
    end
  end

  always_comb begin
    done_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (cmd.command) inside
            CMD_RESTART, CMD_WRITE, CMD_LOAD_OP: done_next = 1'b1;
            CMD_READ: done_next = 1'b0;
            default: done_next = (count == '0);
          endcase
        end
      end
      S_RDWAIT: done_next = 1'b1;
      S_EXEC: done_next = hit || walk_end;
      default: done_next = 1'b0;
    endcase
  end

  sbe_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_word_ram (
    .clk(clk), .we(word_we), .waddr(word_waddr), .wdata(word_wdata),
    .raddr(word_raddr), .rdata(word_rdata)
  );

  sbe_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_mask_ram (
    .clk(clk), .we(mask_we), .waddr(pos), .wdata(mask_wdata),
    .raddr(data_raddr), .rdata(mask_rdata)
  );

  sbe_ram #(.WIDTH(WORD_BITS), .DEPTH(MAX_WORDS)) u_op_ram (
    .clk(clk), .we(op_we), .waddr(cmd.word_index),
    .wdata(cmd.data_word[WORD_BITS-1:0]),
    .raddr(data_raddr), .rdata(op_rdata)
  );

  sbe_ram #(.WIDTH(IDX_W), .DEPTH(MAX_WORDS)) u_list_ram (
    .clk(clk), .we(list_we), .waddr(slot), .wdata(last_pos),
    .raddr(slot), .rdata(list_rdata)
  );

  sbe_ram #(.WIDTH(IDX_W), .DEPTH(MAX_WORDS)) u_last_ram (
    .clk(clk), .we(list_we), .waddr(slot), .wdata(last_pos),
    .raddr(last_slot), .rdata(last_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= CMD_RESTART;
      idx           <= '0;
      set_size_bits <= '0;
      count         <= '0;
      slot          <= '0;
      pos           <= '0;
      last_pos      <= '0;
      word_valid    <= '0;
      mask_valid    <= '0;
      list_valid    <= '0;
      done          <= 1'b0;
      result        <= '0;
    end else begin
      done <= done_next;
      if (cfg_we) begin
        set_size_bits <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            op  <= cmd.command;
            idx <= cmd.word_index;
            result <= '{none_active: (accept_count == '0), found: 1'b0,
                        found_position: '0, read_data: '0,
                        active_words: accept_count};
            unique case (cmd.command)
              CMD_RESTART: begin
                word_valid <= '0;
                mask_valid <= '0;
                list_valid <= '0;
                count      <= restart_count;
              end
              CMD_WRITE: begin
                word_valid[cmd.word_index] <= 1'b1;
              end
              CMD_LOAD_OP: begin
              end
              CMD_READ: begin
                state <= S_RDWAIT;
              end
              default: begin
                if (count != '0) begin
                  slot  <= (cmd.command == CMD_INTERSECT) ? last_slot : '0;
                  state <= S_LIST;
                end
              end
            endcase
          end
        end
        S_RDWAIT: begin
          result.read_data <= DATA_W'(word_valid[idx] ? word_rdata : '0);
          state <= S_IDLE;
        end
        S_LIST: begin
          state <= S_DATA;
        end
        S_DATA: begin
          pos      <= pos_next;
          last_pos <= last_next;
          state    <= S_EXEC;
        end
        S_EXEC: begin
          if (op == CMD_CLEAR) begin
            mask_valid[pos] <= 1'b0;
          end
          if (op == CMD_OR_MASK) begin
            mask_valid[pos] <= 1'b1;
          end
          if (drop) begin
            list_valid[slot] <= 1'b1;
          end
          count <= count_next;
          if (hit || walk_end) begin
            result.found          <= hit;
            result.found_position <= hit ? pos : '0;
            result.active_words   <= count_next;
            result.none_active    <= (count_next == '0);
            state <= S_IDLE;
          end else begin
            slot  <= (op == CMD_INTERSECT) ? slot - IDX_W'(1) : slot + IDX_W'(1);
            state <= S_LIST;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* tb/sbe_checker.sv */
// ----------------------------------------------------------------------------
// sbe_checker
// Watches command and result beats of the sparse bitset engine, keeps its own
// copy of the word, mask and operand stores and the active list, predicts each
// result beat and compares it field by field against the block.
// ----------------------------------------------------------------------------
module sbe_checker
  import sbe_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  in_beat_t          cmd,
  input  logic              done,
  input  out_beat_t         result,
  input  logic              cfg_we,
  input  logic [SIZE_W-1:0] cfg_data,
  output int                errors,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WORD_BITS-1:0] words   [MAX_WORDS];
  logic [WORD_BITS-1:0] masks   [MAX_WORDS];
  logic [WORD_BITS-1:0] operands[MAX_WORDS];
  logic [IDX_W-1:0]     order   [MAX_WORDS];
  int                   live;
  logic [SIZE_W-1:0]    size_bits;
  out_beat_t            answers[$];

  assign pending = answers.size();

  function automatic out_beat_t apply_command(in_beat_t c);
    out_beat_t r;
    int n;
    int p;
    logic [WORD_BITS-1:0] w;
    r = '0;
    case (c.command)
      CMD_RESTART: begin
        n = (size_bits != 0) ? (int'(size_bits) - 1) / WORD_BITS + 1 : 0;
        if (n > MAX_WORDS) n = MAX_WORDS;
        for (int i = 0; i < MAX_WORDS; i++) begin
          words[i] = '0;
          masks[i] = '0;
          order[i] = IDX_W'(i);
        end
        live = n;
      end
      CMD_WRITE: words[c.word_index] = c.data_word;
      CMD_LOAD_OP: operands[c.word_index] = c.data_word;
      CMD_READ: r.read_data = words[c.word_index];
      CMD_CLEAR: for (int i = 0; i < live; i++) masks[order[i]] = '0;
      CMD_OR_MASK: for (int i = 0; i < live; i++) masks[order[i]] |= operands[order[i]];
      CMD_INTERSECT: begin
        for (int i = live - 1; i >= 0; i--) begin
          p = order[i];
          w = words[p] & masks[p];
          if (w != words[p]) begin
            words[p] = w;
            if (w == '0) begin
              order[i] = order[live - 1];
              live--;
            end
          end
        end
      end
      default: begin
        for (int i = 0; i < live; i++) begin
          if ((words[order[i]] & operands[order[i]]) != '0) begin
            r.found = 1'b1;
            r.found_position = order[i];
            break;
          end
        end
      end
    endcase
    r.none_active = (live == 0);
    r.active_words = CNT_W'(live);
    return r;
  endfunction

  always @(posedge clk) begin
    out_beat_t e;
    if (rst) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
        words[i] = '0;
        masks[i] = '0;
        operands[i] = '0;
        order[i] = IDX_W'(i);
      end
      live = 0;
      size_bits = '0;
      errors = 0;
      answers.delete();
    end else begin
      if (cfg_we) size_bits = cfg_data;
      if (done) begin
        if (answers.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %h", result);
        end else begin
          e = answers.pop_front();
          if (result.none_active !== e.none_active || result.found !== e.found ||
              result.found_position !== e.found_position ||
              result.read_data !== e.read_data ||
              result.active_words !== e.active_words) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: expected %h actual %h", e, result);
          end
        end
      end
      if (start && !busy) answers.push_back(apply_command(cmd));
    end
  end
endmodule

/* tb/tb_sparse_bitset_engine.sv */
// ----------------------------------------------------------------------------
// tb_sparse_bitset_engine
// Drives directed command beats and then random ones, mostly with random gaps,
// into the sparse bitset engine, changes the size register between phases, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_sparse_bitset_engine;
  import sbe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  in_beat_t          cmd = '0;
  logic              done;
  out_beat_t         result;
  logic              cfg_we = 1'b0;
  logic [SIZE_W-1:0] cfg_data = '0;
  int                errors;
  int                pending;
  logic [MAX_WORDS-1:0] loaded = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sparse_bitset_engine dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  sbe_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send(cmd_t c, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] d,
                      bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    // operand reads only touch entries already loaded
    if ((c == CMD_OR_MASK || c == CMD_FIND) && loaded != '1) begin
      c = CMD_LOAD_OP;
    end
    if (c == CMD_LOAD_OP) loaded[idx] = 1'b1;
    start <= 1'b1;
    cmd <= '{command: c, word_index: idx, data_word: d};
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_size(logic [SIZE_W-1:0] v);
    start <= 1'b0;
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [SIZE_W-1:0] sizes[6];
    cmd_t c;
    int r;
    sizes = '{13'd4096, 13'd0, 13'd1, 13'd8191, 13'd65, 13'd640};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < MAX_WORDS; i++) send(CMD_LOAD_OP, IDX_W'(i), '0, 0);
    set_size(13'd130);
    send(CMD_RESTART, 0, '0, 0);
    send(CMD_WRITE, 0, '1, 0);
    send(CMD_WRITE, 63, 64'h8000_0000_0000_0001, 0);
    send(CMD_READ, 63, '0, 0);
    send(CMD_READ, 0, '0, 0);
    send(CMD_LOAD_OP, 1, '1, 0);
    send(CMD_FIND, 0, '0, 0);
    send(CMD_LOAD_OP, 0, 64'hF0, 0);
    send(CMD_FIND, 0, '0, 0);
    send(CMD_CLEAR, 0, '0, 0);
    send(CMD_OR_MASK, 0, '0, 0);
    send(CMD_INTERSECT, 0, '0, 0);
    send(CMD_READ, 0, '0, 0);
    send(CMD_CLEAR, 0, '0, 0);
    send(CMD_INTERSECT, 0, '0, 0);
    send(CMD_FIND, 0, '0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      set_size(ph == 5 ? 13'($urandom_range(1, 4096)) : sizes[ph]);
      send(CMD_RESTART, 0, '0, 1);
      for (int k = 0; k < 130; k++) begin
        r = $urandom_range(0, 99);
        if (r < 30) c = CMD_WRITE;
        else if (r < 50) c = CMD_LOAD_OP;
        else if (r < 58) c = CMD_READ;
        else if (r < 66) c = CMD_CLEAR;
        else if (r < 76) c = CMD_OR_MASK;
        else if (r < 86) c = CMD_INTERSECT;
        else if (r < 97) c = CMD_FIND;
        else c = CMD_RESTART;
        send(c, IDX_W'($urandom), rand_word(), k > 20);
        if (k == 60) begin
          start <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end
endmodule

/* filelist.f */
src/sbe_pkg.sv
src/sbe_ram.sv
src/sparse_bitset_engine.sv
tb/sbe_checker.sv
tb/tb_sparse_bitset_engine.sv
